### hdl/remh_pkg.sv
// Shared types and constants for the relative-error minimum histogram.
// No dependencies; imported by every module of the block.
package remh_pkg;

  localparam int NUM_BINS_DEF   = 20;
  localparam int COUNT_BITS_DEF = 32;

  localparam int CMD_W      = 2;
  localparam int PROB_W     = 16;
  localparam int SEL_W      = 5;
  localparam int ERR_W      = 16;
  localparam int BIN_OUT_W  = 5;
  localparam int CNT_OUT_W  = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam int SUM_W   = PROB_W + 1;
  localparam int QUOT_W  = 15;
  localparam int STEP_W  = 4;
  localparam int FRAC_W  = 14;
  localparam int BCMP_W  = 9;
  localparam int PROD_W  = QUOT_W + BCMP_W;
  localparam int CEIL_W  = PROD_W + 1;

  localparam logic [ERR_W-1:0] ONE_Q14  = 16'd16384;
  localparam logic [ERR_W-1:0] ROUND_UP = 16'd16383;
  localparam logic [ERR_W-1:0] NONE_ERR = 16'd32768;

  typedef enum logic [CMD_W-1:0] {
    CMD_CAND  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COARSE_THR = 1'd0,
    CFG_FINE_THR   = 1'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_BIN,
    ST_UPD,
    ST_RDW,
    ST_RESP
  } state_e;

endpackage

### hdl/relative_error_min_histogram_unit.sv
// Relative-error minimum histogram. Takes one request at a time (in_ready_o is high only
// when idle). A qualifying candidate pair runs 2|a-b|/(a+b) through a radix-2 divider that
// yields one quotient bit per cycle; a non-qualifying candidate skips the divider. The last
// candidate of a voxel then adds binning and the read-modify-write of the bin counter, with
// no write when the minimum is not counted. Results sit in an output register, so the next
// request is taken while a result waits; a request that gives a result holds in ST_RESP
// until that register is free.
// Depends on remh_pkg, remh_div and remh_hist.
module relative_error_min_histogram_unit import remh_pkg::*; #(
  parameter int NUM_BINS   = NUM_BINS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [CMD_W-1:0]      cmd_i,
  input  logic [PROB_W-1:0]     coarse_prob_i,
  input  logic [PROB_W-1:0]     fine_prob_i,
  input  logic                  fine_in_range_i,
  input  logic                  last_candidate_i,
  input  logic [SEL_W-1:0]      bin_select_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  counted_o,
  output logic [BIN_OUT_W-1:0]  bin_index_o,
  output logic [ERR_W-1:0]      min_error_o,
  output logic [CNT_OUT_W-1:0]  bin_count_o
);

  localparam int BIN_W = $clog2(NUM_BINS);

  state_e                state_q, state_d;
  logic [PROB_W-1:0]     cthr_q, fthr_q;
  logic [ERR_W-1:0]      run_min_q, run_min_d;
  logic                  last_q, last_d;
  logic                  sel_ok_q, sel_ok_d;
  logic [BIN_W-1:0]      bin_q, bin_d;
  logic                  res_cnt_q, res_cnt_d;
  logic [BIN_OUT_W-1:0]  res_bin_q, res_bin_d;
  logic [ERR_W-1:0]      res_min_q, res_min_d;
  logic [CNT_OUT_W-1:0]  res_count_q, res_count_d;
  logic                  out_valid_q, out_valid_d;
  logic                  out_cnt_q, out_cnt_d;
  logic [BIN_OUT_W-1:0]  out_bin_q, out_bin_d;
  logic [ERR_W-1:0]      out_min_q, out_min_d;
  logic [CNT_OUT_W-1:0]  out_count_q, out_count_d;

  logic [PROB_W-1:0]     diff;
  logic [SUM_W-1:0]      sum;
  logic                  qualify;
  logic                  sel_ok;
  logic                  div_start, div_done;
  logic [QUOT_W-1:0]     div_quot;
  logic [QUOT_W-1:0]     m15;
  logic [PROD_W-1:0]     prod;
  logic [CEIL_W-1:0]     ceil_sum;
  logic [CEIL_W-FRAC_W-1:0] nb;
  logic [BIN_W-1:0]      bin_calc;
  logic                  cnt_ok;

  logic                  h_clr, h_rd, h_wr;
  logic [BIN_W-1:0]      h_rd_addr;
  logic [COUNT_BITS-1:0] h_rd_data;

  assign diff    = (coarse_prob_i > fine_prob_i) ? coarse_prob_i - fine_prob_i
                                                 : fine_prob_i - coarse_prob_i;
  assign sum     = SUM_W'(coarse_prob_i) + SUM_W'(fine_prob_i);
  assign qualify = fine_in_range_i && (coarse_prob_i > cthr_q) && (fine_prob_i > fthr_q);
  assign sel_ok  = BCMP_W'(bin_select_i) < BCMP_W'(NUM_BINS);

  // bin = ceil(err * NUM_BINS / 1.0) - 1, error of zero to bin 0
  assign m15      = run_min_q[QUOT_W-1:0];
  assign prod     = PROD_W'(m15) * PROD_W'(NUM_BINS);
  assign ceil_sum = CEIL_W'(prod) + CEIL_W'(ROUND_UP);
  assign nb       = ceil_sum[CEIL_W-1:FRAC_W];
  assign bin_calc = (run_min_q == '0) ? '0 : BIN_W'(nb - 1'b1);
  assign cnt_ok   = run_min_q <= ONE_Q14;

  remh_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (diff),
    .divisor_i  (sum),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  remh_hist #(
    .NUM_BINS   (NUM_BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_hist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_i     (h_clr),
    .rd_en_i   (h_rd),
    .rd_addr_i (h_rd_addr),
    .wr_en_i   (h_wr),
    .wr_addr_i (bin_q),
    .wr_data_i (h_rd_data + 1'b1),
    .rd_data_o (h_rd_data)
  );

  always_comb begin
    state_d     = state_q;
    run_min_d   = run_min_q;
    last_d      = last_q;
    sel_ok_d    = sel_ok_q;
    bin_d       = bin_q;
    res_cnt_d   = res_cnt_q;
    res_bin_d   = res_bin_q;
    res_min_d   = res_min_q;
    res_count_d = res_count_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_cnt_d   = out_cnt_q;
    out_bin_d   = out_bin_q;
    out_min_d   = out_min_q;
    out_count_d = out_count_q;
    div_start   = 1'b0;
    h_clr       = 1'b0;
    h_rd        = 1'b0;
    h_wr        = 1'b0;
    h_rd_addr   = bin_calc;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (cmd_e'(cmd_i))
            CMD_CAND: begin
              last_d = last_candidate_i;
              if (qualify) begin
                div_start = 1'b1;
                state_d   = ST_DIV;
              end else if (last_candidate_i) begin
                state_d = ST_BIN;
              end
            end
            CMD_READ: begin
              sel_ok_d    = sel_ok;
              h_rd        = sel_ok;
              h_rd_addr   = BIN_W'(bin_select_i);
              res_cnt_d   = 1'b0;
              res_bin_d   = bin_select_i;
              res_min_d   = NONE_ERR;
              state_d     = ST_RDW;
            end
            CMD_CLEAR: h_clr = 1'b1;
            default: ;
          endcase
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if (ERR_W'(div_quot) < run_min_q) begin
            run_min_d = ERR_W'(div_quot);
          end
          state_d = last_q ? ST_BIN : ST_IDLE;
        end
      end
      ST_BIN: begin
        h_rd        = cnt_ok;
        bin_d       = bin_calc;
        res_cnt_d   = cnt_ok;
        res_bin_d   = cnt_ok ? BIN_OUT_W'(bin_calc) : '0;
        res_min_d   = run_min_q;
        res_count_d = '0;
        run_min_d   = NONE_ERR;
        state_d     = cnt_ok ? ST_UPD : ST_RESP;
      end
      ST_UPD: begin
        h_wr    = 1'b1;
        state_d = ST_RESP;
      end
      ST_RDW: begin
        res_count_d = sel_ok_q ? CNT_OUT_W'(h_rd_data) : '0;
        state_d     = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_cnt_d   = res_cnt_q;
          out_bin_d   = res_bin_q;
          out_min_d   = res_min_q;
          out_count_d = res_count_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cthr_q      <= '0;
      fthr_q      <= '0;
      run_min_q   <= NONE_ERR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      run_min_q   <= run_min_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_COARSE_THR: cthr_q <= cfg_wdata_i;
          CFG_FINE_THR:   fthr_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    last_q      <= last_d;
    sel_ok_q    <= sel_ok_d;
    bin_q       <= bin_d;
    res_cnt_q   <= res_cnt_d;
    res_bin_q   <= res_bin_d;
    res_min_q   <= res_min_d;
    res_count_q <= res_count_d;
    out_cnt_q   <= out_cnt_d;
    out_bin_q   <= out_bin_d;
    out_min_q   <= out_min_d;
    out_count_q <= out_count_d;
  end

  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign counted_o   = out_cnt_q;
  assign bin_index_o = out_bin_q;
  assign min_error_o = out_min_q;
  assign bin_count_o = out_count_q;

endmodule

### hdl/remh_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on remh_pkg; computes floor(dividend * 2^QUOT_W / divisor), dividend < divisor.
module remh_div import remh_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [PROB_W-1:0] dividend_i,
  input  logic [SUM_W-1:0]  divisor_i,
  output logic              done_o,
  output logic [QUOT_W-1:0] quot_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [SUM_W-1:0]  rem_q, rem_d;
  logic [SUM_W-1:0]  dvs_q, dvs_d;
  logic [QUOT_W-1:0] quot_q, quot_d;
  logic [SUM_W:0]    rem2;
  logic              ge;

  always_comb begin
    rem2   = {rem_q, 1'b0};
    ge     = rem2 >= {1'b0, dvs_q};
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = SUM_W'(dividend_i);
      dvs_d  = divisor_i;
      quot_d = '0;
    end else if (busy_q) begin
      rem_d  = ge ? SUM_W'(rem2 - {1'b0, dvs_q}) : rem2[SUM_W-1:0];
      quot_d = {quot_q[QUOT_W-2:0], ge};
      step_d = step_q + 1'b1;
      if (step_q == STEP_W'(QUOT_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

### hdl/remh_hist.sv
// Histogram bin storage: 1R1W memory with registered read and per-bin valid bits.
// Depends on remh_pkg; an entry never written since reset or clear reads as zero.
module remh_hist import remh_pkg::*; #(
  parameter int NUM_BINS   = NUM_BINS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  localparam int BIN_W     = $clog2(NUM_BINS)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  clr_i,
  input  logic                  rd_en_i,
  input  logic [BIN_W-1:0]      rd_addr_i,
  input  logic                  wr_en_i,
  input  logic [BIN_W-1:0]      wr_addr_i,
  input  logic [COUNT_BITS-1:0] wr_data_i,
  output logic [COUNT_BITS-1:0] rd_data_o
);

  logic [COUNT_BITS-1:0] mem_q [NUM_BINS];
  logic [NUM_BINS-1:0]   vld_q;
  logic [COUNT_BITS-1:0] rd_data_q;
  logic                  rd_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (clr_i) begin
        vld_q <= '0;
      end else if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule
